@@ rtl/gbd_pkg.sv @@
package gbd_pkg;

   // sync pair and checksum seed
   localparam logic [7:0]  SYNC_FIRST  = 8'h57;
   localparam logic [7:0]  SYNC_SECOND = 8'hF1;
   localparam logic [15:0] SUM_SEED    = 16'hF157;

   // configuration register indexes
   localparam logic [1:0] CSR_MISC_ID  = 2'd0;
   localparam logic [1:0] CSR_GEO_ID_A = 2'd1;
   localparam logic [1:0] CSR_GEO_ID_B = 2'd2;

   // route classes
   localparam logic [1:0] ROUTE_MISC    = 2'd0;
   localparam logic [1:0] ROUTE_GEO     = 2'd1;
   localparam logic [1:0] ROUTE_DISCARD = 2'd2;

   // routing ids held by the register file
   typedef struct packed {
      logic [7:0] misc_message_id;
      logic [7:0] geo_message_id_a;
      logic [7:0] geo_message_id_b;
   } route_ids_type;

   // one result item
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic [7:0] message_id;
      logic [7:0] word_count;
      logic       packet_last;
      logic       checksum_ok;
      logic [1:0] route_class;
   } rsp_item_type;

   // 16-bit add with end-around carry
   function automatic logic [15:0] eac_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // route class from a message id, misc id wins on overlap
   function automatic logic [1:0] route_of(input logic [7:0] id, input route_ids_type ids);
      logic [1:0] r;
      if (id == ids.misc_message_id) begin
         r = ROUTE_MISC;
      end else if (id == ids.geo_message_id_a || id == ids.geo_message_id_b) begin
         r = ROUTE_GEO;
      end else begin
         r = ROUTE_DISCARD;
      end
      return r;
   endfunction

endpackage

@@ rtl/gbd_csr.sv @@
module gbd_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_data,
   output gbd_pkg::route_ids_type ids
);

   gbd_pkg::route_ids_type ids_ff;
   gbd_pkg::route_ids_type ids_in;

   assign csr_ready = 1'b1;

   // register write decode, unknown indexes ignored
   always_comb begin
      ids_in = ids_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gbd_pkg::CSR_MISC_ID:  ids_in.misc_message_id  = csr_data;
            gbd_pkg::CSR_GEO_ID_A: ids_in.geo_message_id_a = csr_data;
            gbd_pkg::CSR_GEO_ID_B: ids_in.geo_message_id_b = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ids_ff.misc_message_id  <= 8'd102;
         ids_ff.geo_message_id_a <= 8'd149;
         ids_ff.geo_message_id_b <= 8'd152;
      end else begin
         ids_ff <= ids_in;
      end
   end

   assign ids = ids_ff;

endmodule

@@ rtl/gbd_parser.sv @@
module gbd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             byte_in,
   input  gbd_pkg::route_ids_type ids,
   output logic                   emit,
   output gbd_pkg::rsp_item_type  result
);

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_COUNT = 3'd1;
   localparam logic [2:0] PH_ID    = 3'd2;
   localparam logic [2:0] PH_CK_LO = 3'd3;
   localparam logic [2:0] PH_CK_HI = 3'd4;
   localparam logic [2:0] PH_EVEN  = 3'd5;
   localparam logic [2:0] PH_ODD   = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic        sync_ff, sync_in;
   logic [7:0]  words_left_ff, words_left_in;
   logic [7:0]  held_id_ff, held_id_in;
   logic [7:0]  held_count_ff, held_count_in;
   logic [15:0] rx_sum_ff, rx_sum_in;
   logic [15:0] run_sum_ff, run_sum_in;
   logic [7:0]  low_hold_ff, low_hold_in;
   logic        last;

   // next state and result for one byte
   always_comb begin
      phase_in      = phase_ff;
      sync_in       = sync_ff;
      words_left_in = words_left_ff;
      held_id_in    = held_id_ff;
      held_count_in = held_count_ff;
      rx_sum_in     = rx_sum_ff;
      run_sum_in    = run_sum_ff;
      low_hold_in   = low_hold_ff;
      emit          = 1'b0;
      last          = 1'b0;
      result.payload_byte = 8'd0;
      result.has_byte     = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (sync_ff && byte_in == gbd_pkg::SYNC_SECOND) begin
               sync_in  = 1'b0;
               phase_in = PH_COUNT;
            end else begin
               // a stray sync-first byte keeps the match alive
               sync_in = (byte_in == gbd_pkg::SYNC_FIRST);
            end
         end
         PH_COUNT: begin
            held_count_in = byte_in;
            phase_in      = PH_ID;
         end
         PH_ID: begin
            held_id_in = byte_in;
            run_sum_in = gbd_pkg::eac_add(gbd_pkg::SUM_SEED, {byte_in, held_count_ff});
            phase_in   = PH_CK_LO;
         end
         PH_CK_LO: begin
            rx_sum_in = {8'd0, byte_in};
            phase_in  = PH_CK_HI;
         end
         PH_CK_HI: begin
            rx_sum_in = {byte_in, rx_sum_ff[7:0]};
            if (held_count_ff == 8'd0) begin
               // empty packet ends here with a dataless item
               phase_in = PH_HUNT;
               emit     = 1'b1;
               last     = 1'b1;
            end else begin
               words_left_in = held_count_ff;
               phase_in      = PH_EVEN;
            end
         end
         PH_EVEN: begin
            low_hold_in         = byte_in;
            phase_in            = PH_ODD;
            emit                = 1'b1;
            result.payload_byte = byte_in;
            result.has_byte     = 1'b1;
         end
         PH_ODD: begin
            run_sum_in    = gbd_pkg::eac_add(run_sum_ff, {byte_in, low_hold_ff});
            words_left_in = words_left_ff - 8'd1;
            emit                = 1'b1;
            result.payload_byte = byte_in;
            result.has_byte     = 1'b1;
            if (words_left_ff == 8'd1) begin
               phase_in = PH_HUNT;
               last     = 1'b1;
            end else begin
               phase_in = PH_EVEN;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            sync_in  = 1'b0;
         end
      endcase
      result.message_id  = held_id_in;
      result.word_count  = held_count_in;
      result.packet_last = last;
      result.checksum_ok = last && (run_sum_in == rx_sum_in);
      result.route_class = last ? gbd_pkg::route_of(held_id_in, ids) : gbd_pkg::ROUTE_MISC;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         sync_ff       <= 1'b0;
         words_left_ff <= 8'd0;
         held_id_ff    <= 8'd0;
         held_count_ff <= 8'd0;
         rx_sum_ff     <= 16'd0;
         run_sum_ff    <= 16'd0;
         low_hold_ff   <= 8'd0;
      end else if (take) begin
         phase_ff      <= phase_in;
         sync_ff       <= sync_in;
         words_left_ff <= words_left_in;
         held_id_ff    <= held_id_in;
         held_count_ff <= held_count_in;
         rx_sum_ff     <= rx_sum_in;
         run_sum_ff    <= run_sum_in;
         low_hold_ff   <= low_hold_in;
      end
   end

endmodule

@@ rtl/gnss_binary_packet_deframer.sv @@
// timing: a payload byte or empty-packet end appears on rsp in the cycle after its byte is taken
// throughput: one byte per cycle while req_stall is low, set by the parser update and one 16-bit add
// req_stall rises only while a result is held and rsp_stall is high
// reset: synchronous, active high; parser returns to sync hunt, ids to 102, 149, 152
// header bytes produce no result, except the last checksum byte of an empty packet
module gnss_binary_packet_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_message_id,
   output logic [7:0] rsp_word_count,
   output logic       rsp_packet_last,
   output logic       rsp_checksum_ok,
   output logic [1:0] rsp_route_class,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   gbd_pkg::route_ids_type ids;
   gbd_pkg::rsp_item_type  result;
   gbd_pkg::rsp_item_type  rsp_ff;
   logic                   emit;
   logic                   take;
   logic                   rsp_valid_ff, rsp_valid_in;

   // accept while the result register is empty or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   gbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ids       (ids)
   );

   gbd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .byte_in (req_byte_in),
      .ids     (ids),
      .emit    (emit),
      .result  (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_has_byte     = rsp_ff.has_byte;
   assign rsp_message_id   = rsp_ff.message_id;
   assign rsp_word_count   = rsp_ff.word_count;
   assign rsp_packet_last  = rsp_ff.packet_last;
   assign rsp_checksum_ok  = rsp_ff.checksum_ok;
   assign rsp_route_class  = rsp_ff.route_class;

endmodule
